>>> src/kit_pkg.sv
// kit_pkg: shared types, constants and the symbol-to-text translation for
// the keysym intern table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kit_pkg;

    // Default table geometry
    localparam int KIT_TABLE_ENTRIES = 256;
    localparam int KIT_FIRST_CODE    = 8;

    // Fixed field widths
    localparam int SYM_W     = 29;
    localparam int CODE_IN_W = 9;
    localparam int CODE_W    = 8;
    localparam int CHAR_W    = 8;

    // Operation codes
    localparam logic KIT_OP_INTERN = 1'b0;
    localparam logic KIT_OP_LOOKUP = 1'b1;

    // Translation ranges and special symbols
    localparam logic [SYM_W-1:0] KIT_PRINT_LO  = SYM_W'(32'h20);
    localparam logic [SYM_W-1:0] KIT_PRINT_HI  = SYM_W'(32'h7e);
    localparam logic [SYM_W-1:0] KIT_LATIN_LO  = SYM_W'(32'ha0);
    localparam logic [SYM_W-1:0] KIT_LATIN_HI  = SYM_W'(32'hff);
    localparam logic [SYM_W-1:0] KIT_SYM_RET   = SYM_W'(32'hff0d);
    localparam logic [SYM_W-1:0] KIT_SYM_TAB   = SYM_W'(32'hff09);
    localparam logic [SYM_W-1:0] KIT_SYM_BKSP  = SYM_W'(32'hff08);
    localparam logic [SYM_W-1:0] KIT_SYM_ESC   = SYM_W'(32'hff1b);
    localparam logic [SYM_W-1:0] KIT_SYM_DEL   = SYM_W'(32'hffff);

    localparam logic [CHAR_W-1:0] KIT_CH_RET  = 8'h0d;
    localparam logic [CHAR_W-1:0] KIT_CH_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0] KIT_CH_BKSP = 8'h08;
    localparam logic [CHAR_W-1:0] KIT_CH_ESC  = 8'h1b;
    localparam logic [CHAR_W-1:0] KIT_CH_DEL  = 8'h7f;

    // Request payload
    typedef struct packed {
        logic                 operation;
        logic [SYM_W-1:0]     symbol_in;
        logic [CODE_IN_W-1:0] code_in;
        logic                 text_wanted;
    } kit_req_t;

    // Response payload
    typedef struct packed {
        logic [CODE_W-1:0] code_out;
        logic [SYM_W-1:0]  symbol_out;
        logic [CHAR_W-1:0] text_byte;
        logic              text_count;
    } kit_rsp_t;

    // Translation result
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
    } kit_xlate_t;

    // Symbol to one character byte
    function automatic kit_xlate_t kit_translate(input logic [SYM_W-1:0] sym);
        kit_xlate_t x;
        x.valid = 1'b1;
        x.ch    = sym[CHAR_W-1:0];
        if (!((sym >= KIT_PRINT_LO && sym <= KIT_PRINT_HI) ||
              (sym >= KIT_LATIN_LO && sym <= KIT_LATIN_HI)))
        begin
            case (sym)
                KIT_SYM_RET:  x.ch = KIT_CH_RET;
                KIT_SYM_TAB:  x.ch = KIT_CH_TAB;
                KIT_SYM_BKSP: x.ch = KIT_CH_BKSP;
                KIT_SYM_ESC:  x.ch = KIT_CH_ESC;
                KIT_SYM_DEL:  x.ch = KIT_CH_DEL;
                default:
                begin
                    x.valid = 1'b0;
                    x.ch    = '0;
                end
            endcase
        end
        return x;
    endfunction

endpackage

`default_nettype wire

>>> src/keysym_intern_table.sv
// keysym_intern_table: intern symbols to small codes, look codes back up.
// Intern: linear scan of allocated slots through the store's single read
// port, one slot per cycle. One request at a time. Reset empties the table
// at once: slots at or above the fill pointer read as zero, so no clearing
// pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module keysym_intern_table
    import kit_pkg::*;
#(
    parameter int TABLE_ENTRIES = KIT_TABLE_ENTRIES,
    parameter int FIRST_CODE    = KIT_FIRST_CODE
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire kit_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output kit_rsp_t      rsp
);

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W  = CODE_IN_W + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t           state_reg,    state_next;
    logic [CNT_W-1:0] next_free_reg, next_free_next;
    logic [CNT_W-1:0] idx_reg,      idx_next;
    logic             cmp_vld_reg,  cmp_vld_next;
    logic [CNT_W-1:0] cmp_idx_reg,  cmp_idx_next;
    logic [SYM_W-1:0] sym_reg,      sym_next;
    logic             want_reg,     want_next;
    logic             hit_reg,      hit_next;
    kit_rsp_t         rsp_reg,      rsp_next;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [SYM_W-1:0]  rd_data;
    logic [SYM_W-1:0]  look_sym;
    kit_xlate_t        xlate;

    kit_store #(
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (sym_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Lookup data: only allocated slots hold symbols
    assign look_sym = hit_reg ? rd_data : '0;
    assign xlate    = kit_translate(look_sym);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        next_free_next = next_free_reg;
        idx_next       = idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        sym_next       = sym_reg;
        want_next      = want_reg;
        hit_next       = hit_reg;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = next_free_reg[ADDR_W-1:0];
        rd_addr        = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    sym_next  = req.symbol_in;
                    want_next = req.text_wanted;
                    if (req.operation == KIT_OP_INTERN)
                    begin
                        if (req.symbol_in == '0)
                        begin
                            rsp_next   = '0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next     = CNT_W'(FIRST_CODE);
                            cmp_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                    end
                    else
                    begin
                        rd_addr  = req.code_in[ADDR_W-1:0];
                        hit_next = ({1'b0, req.code_in} >= CMP_W'(FIRST_CODE)) &&
                                   ({1'b0, req.code_in} < CMP_W'(next_free_reg));
                        state_next = S_READ;
                    end
                end
            end

            // Issue one slot read per cycle, compare the previous one
            S_SCAN:
            begin
                if (cmp_vld_reg && rd_data == sym_reg)
                begin
                    rsp_next          = '0;
                    rsp_next.code_out = CODE_W'(cmp_idx_reg);
                    state_next        = S_DONE;
                end
                else if (idx_reg < next_free_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg;
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else if (cmp_vld_reg)
                begin
                    cmp_vld_next = 1'b0;
                end
                else
                begin
                    // Miss: allocate unless full
                    rsp_next = '0;
                    if (next_free_reg != CNT_W'(TABLE_ENTRIES))
                    begin
                        wr_en             = 1'b1;
                        rsp_next.code_out = CODE_W'(next_free_reg);
                        next_free_next    = next_free_reg + CNT_W'(1);
                    end
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                rsp_next            = '0;
                rsp_next.symbol_out = look_sym;
                if (want_reg && xlate.valid)
                begin
                    rsp_next.text_byte  = xlate.ch;
                    rsp_next.text_count = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= CNT_W'(FIRST_CODE);
            cmp_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            cmp_vld_reg   <= cmp_vld_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        sym_reg     <= sym_next;
        want_reg    <= want_next;
        hit_reg     <= hit_next;
        rsp_reg     <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_DONE);
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> src/kit_store.sv
// kit_store: symbol memory, one write port and one registered read port.
// Depends on kit_pkg for the symbol width.
`timescale 1ns / 1ps
`default_nettype none

module kit_store
    import kit_pkg::*;
#(
    parameter int DEPTH  = KIT_TABLE_ENTRIES,
    parameter int ADDR_W = $clog2(KIT_TABLE_ENTRIES)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [SYM_W-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [SYM_W-1:0]  rd_data
);

    logic [SYM_W-1:0] mem [DEPTH];
    logic [SYM_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/kit_checker.sv
// kit_checker: port-level checks for keysym_intern_table, bound to the top.
// Depends on kit_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

module kit_checker
    import kit_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire kit_rsp_t rsp
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // One request in flight: no new request while a response waits
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while response pending");

    // An accepted request takes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready right after accept");

    // No text byte without a text count
    a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.text_count |-> rsp.text_byte == '0)
        else $error("text byte without count");

    // Intern results carry no symbol or text; lookups carry no code
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.code_out == '0 ||
                      (rsp.symbol_out == '0 && !rsp.text_count))
        else $error("mixed intern and lookup result");

endmodule

bind keysym_intern_table kit_checker u_kit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> test/keysym_table_checker.sv
// keysym_table_checker: watches both channels of the keysym intern table, keeps its own
// copy of the symbol table, and compares every response with the one it predicts.
// Depends on kit_pkg for the request/response types and the special symbol constants.
`timescale 1ns / 1ps

module keysym_table_checker
    import kit_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_ready,
    input  wire kit_req_t req,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_ready,
    input  wire kit_rsp_t rsp,
    output int            pending,
    output int            failures
);

    localparam int ENTRIES    = KIT_TABLE_ENTRIES;
    localparam int FIRST      = KIT_FIRST_CODE;
    localparam int REPORT_MAX = 10;

    // Shadow copy of the table
    logic [SYM_W-1:0] slot_sym [ENTRIES];
    int               fill_ptr;

    // Responses still owed by the block, oldest first
    kit_rsp_t         owed_rsp_q[$];
    int               bad_count = 0;

    // {has_char, char} for a symbol
    function automatic logic [CHAR_W:0] keysym_char(input logic [SYM_W-1:0] sym);
        if ((sym >= KIT_PRINT_LO && sym <= KIT_PRINT_HI) ||
            (sym >= KIT_LATIN_LO && sym <= KIT_LATIN_HI))
        begin
            return {1'b1, sym[CHAR_W-1:0]};
        end
        case (sym)
            KIT_SYM_RET:  return {1'b1, 8'h0d};
            KIT_SYM_TAB:  return {1'b1, 8'h09};
            KIT_SYM_BKSP: return {1'b1, 8'h08};
            KIT_SYM_ESC:  return {1'b1, 8'h1b};
            KIT_SYM_DEL:  return {1'b1, 8'h7f};
            default:      return '0;
        endcase
    endfunction

    // Response for one request; interning updates the shadow table
    function automatic kit_rsp_t table_answer(input kit_req_t r);
        kit_rsp_t        a;
        logic [CHAR_W:0] t;
        int              hit;
        int              i;
        a   = '0;
        hit = -1;
        if (r.operation == KIT_OP_INTERN)
        begin
            if (r.symbol_in != '0)
            begin
                // linear search of allocated slots
                for (i = FIRST; i < fill_ptr; i++)
                begin
                    if (hit < 0 && slot_sym[i] == r.symbol_in)
                        hit = i;
                end
                if (hit >= 0)
                    a.code_out = CODE_W'(hit);
                else if (fill_ptr < ENTRIES)
                begin
                    slot_sym[fill_ptr] = r.symbol_in;
                    a.code_out         = CODE_W'(fill_ptr);
                    fill_ptr++;
                end
                // full table and no hit: code stays 0
            end
        end
        else
        begin
            if (r.code_in < ENTRIES)
                a.symbol_out = slot_sym[r.code_in];
            t = keysym_char(a.symbol_out);
            if (r.text_wanted && t[CHAR_W])
            begin
                a.text_count = 1'b1;
                a.text_byte  = t[CHAR_W-1:0];
            end
        end
        return a;
    endfunction

    // Sample both handshakes at the clock edge
    always @(posedge clk or negedge rst_n)
    begin : monitor
        kit_rsp_t due;
        int       k;
        if (!rst_n)
        begin
            owed_rsp_q.delete();
            for (k = 0; k < ENTRIES; k++)
                slot_sym[k] = '0;
            fill_ptr = FIRST;
            pending  <= 0;
        end
        else
        begin
            // response side first: a request taken this edge cannot answer yet
            if (rsp_valid && rsp_ready)
            begin
                if (owed_rsp_q.size() == 0)
                begin
                    if (bad_count < REPORT_MAX)
                        $display("%0t: response with none owed: code %0d symbol %h text %h/%0d",
                                 $realtime, rsp.code_out, rsp.symbol_out, rsp.text_byte,
                                 rsp.text_count);
                    bad_count++;
                end
                else
                begin
                    due = owed_rsp_q.pop_front();
                    if (rsp.code_out !== due.code_out || rsp.symbol_out !== due.symbol_out ||
                        rsp.text_byte !== due.text_byte || rsp.text_count !== due.text_count)
                    begin
                        if (bad_count < REPORT_MAX)
                            $display({"%0t: mismatch: expected code %0d symbol %h text %h/%0d,",
                                      " got code %0d symbol %h text %h/%0d"},
                                     $realtime, due.code_out, due.symbol_out, due.text_byte,
                                     due.text_count, rsp.code_out, rsp.symbol_out,
                                     rsp.text_byte, rsp.text_count);
                        bad_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                owed_rsp_q.push_back(table_answer(req));
            pending <= owed_rsp_q.size();
        end
        failures <= bad_count;
    end

endmodule

>>> test/keysym_intern_table_test.sv
// keysym_intern_table_test: stimulus and verdict for the keysym intern table.
// Drives directed then random requests with bursty sending and stalling receive;
// depends on kit_pkg, keysym_intern_table and keysym_table_checker.
`timescale 1ns / 1ps

module keysym_intern_table_test;
    import kit_pkg::*;

    localparam int RANDOM_ITEMS = 1224;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE_TICKS = 300;   // beyond the longest intern scan
    localparam int HOLD_TICKS   = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 100;   // responses taken before the hold-off
    localparam int PAUSE_AT     = 600;   // random request where the sender drains

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    kit_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    kit_rsp_t rsp;
    int       pending;
    int       failures;
    int       cycle_count = 0;
    int       burst_left  = 0;

    // symbols sent for interning, reused to provoke hits
    logic [SYM_W-1:0] sent_syms[$];

    keysym_intern_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    keysym_table_checker table_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .pending   (pending),
        .failures  (failures)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Request builders; unused fields get random bits
    function automatic kit_req_t make_intern(input logic [SYM_W-1:0] sym);
        kit_req_t r;
        r.operation   = KIT_OP_INTERN;
        r.symbol_in   = sym;
        r.code_in     = CODE_IN_W'($urandom());
        r.text_wanted = 1'($urandom());
        return r;
    endfunction

    function automatic kit_req_t make_lookup(input logic [CODE_IN_W-1:0] code,
                                             input logic want);
        kit_req_t r;
        r.operation   = KIT_OP_LOOKUP;
        r.symbol_in   = SYM_W'($urandom());
        r.code_in     = code;
        r.text_wanted = want;
        return r;
    endfunction

    // Symbol mix: repeats, translatable ranges and their borders, keys, wide values
    function automatic logic [SYM_W-1:0] pick_symbol();
        logic [SYM_W-1:0] keys[8];
        logic [SYM_W-1:0] s;
        int               roll;
        keys = '{KIT_SYM_RET, KIT_SYM_TAB, KIT_SYM_BKSP, KIT_SYM_ESC, KIT_SYM_DEL,
                 SYM_W'(32'hff0e), SYM_W'(32'hff00), SYM_W'(32'hfffe)};
        roll = $urandom_range(99);
        if (roll < 5)
            s = '0;
        else if (roll < 30 && sent_syms.size() > 0)
            s = sent_syms[$urandom_range(sent_syms.size() - 1)];
        else if (roll < 45)
            s = SYM_W'($urandom_range(32'h7f, 32'h1f));
        else if (roll < 55)
            s = SYM_W'($urandom_range(32'h100, 32'h9f));
        else if (roll < 63)
            s = keys[$urandom_range(7)];
        else
            s = SYM_W'($urandom());
        if (s != '0)
            sent_syms.push_back(s);
        return s;
    endfunction

    function automatic logic [CODE_IN_W-1:0] pick_code();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return CODE_IN_W'($urandom_range(255, 0));
        else if (roll < 80)
            return CODE_IN_W'($urandom_range(24, 0));
        return CODE_IN_W'($urandom_range(511, 256));
    endfunction

    // Offer one request and hold it until taken; idle between bursts
    task automatic send_request(input kit_req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req_valid <= 1'b0;
            if ($urandom_range(9) < 8)
                repeat ($urandom_range(6, 1)) @(posedge clk);
            else
                repeat ($urandom_range(30, 10)) @(posedge clk);
            // occasional long burst with no idling at all
            if ($urandom_range(4) == 0)
                burst_left = $urandom_range(60, 30);
            else
                burst_left = $urandom_range(8, 0);
        end
    endtask

    // Stop sending until every response has come back
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Receiver: segments of differing stall rates, one long hold-off
    initial
    begin : receiver
        int pct;
        int seg;
        int served;
        bit held;
        served = 0;
        held   = 1'b0;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            seg = $urandom_range(96, 16);
            case ($urandom_range(3))
                0:       pct = 0;
                1:       pct = 20;
                2:       pct = 50;
                default: pct = 85;
            endcase
            repeat (seg)
            begin
                if (!held && served >= HOLD_AFTER)
                begin
                    held = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (HOLD_TICKS) @(posedge clk);
                end
                rsp_ready <= ($urandom_range(99) >= pct);
                @(posedge clk);
                if (rsp_valid && rsp_ready)
                    served++;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        logic [SYM_W-1:0] corner_syms[10];
        int               n;
        corner_syms = '{KIT_PRINT_LO, KIT_PRINT_HI, KIT_LATIN_LO, KIT_LATIN_HI,
                        KIT_SYM_RET, KIT_SYM_TAB, KIT_SYM_BKSP, KIT_SYM_ESC, KIT_SYM_DEL,
                        {SYM_W{1'b1}}};
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero symbol, first allocation, then a hit on it
        send_request(make_intern('0));
        send_request(make_intern(SYM_W'(32'h41)));
        send_request(make_intern(SYM_W'(32'h41)));
        // range borders, special keys and the widest symbol: codes 9..18
        foreach (corner_syms[k])
            send_request(make_intern(corner_syms[k]));
        for (int c = 9; c <= 18; c++)
            send_request(make_lookup(CODE_IN_W'(c), 1'b1));
        // no text wanted, code below the first one, code out of range
        send_request(make_lookup(CODE_IN_W'(8), 1'b0));
        send_request(make_lookup(CODE_IN_W'(3), 1'b1));
        send_request(make_lookup({CODE_IN_W{1'b1}}, 1'b1));
        wait_drained();

        // random requests; the table fills up part way through
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PAUSE_AT)
                wait_drained();
            if ($urandom_range(99) < 55)
                send_request(make_intern(pick_symbol()));
            else
                send_request(make_lookup(pick_code(), $urandom_range(99) < 80));
        end
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
